FILE: design/assert_macros.svh
// Assertion macros used by the sequencer top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dcas_pkg.sv
// Types, codes and helper functions of the DMA channel address sequencer
package dcas_pkg;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	localparam logic [23:0] BLK_PAGE_MASK = 24'h40ff00;
	localparam logic [23:0] BLK_PAGE_VAL  = 24'h002100;
	localparam logic [23:0] BLK_DMA_MASK  = 24'h40ff80;
	localparam logic [23:0] BLK_DMA_VAL   = 24'h004300;
	localparam logic [23:0] BLK_REG_MASK  = 24'h40ffff;
	localparam logic [23:0] BLK_MDMA_VAL  = 24'h00420b;
	localparam logic [23:0] BLK_HDMA_VAL  = 24'h00420c;
	localparam logic [7:0]  B_OPEN_REG    = 8'h80;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  channel_sel;
		logic        b_to_a_dir;
		logic        fixed_address;
		logic        step_down;
		logic [2:0]  pattern_mode;
		logic [7:0]  b_base;
		logic [7:0]  src_bank;
		logic [15:0] src_address;
		logic [15:0] byte_count;
		logic [7:0]  enable_mask;
	} dcas_in_t;

	typedef struct packed {
		logic        idle;
		logic [2:0]  served_channel;
		logic [23:0] a_address;
		logic [7:0]  b_register;
		logic        b_to_a;
		logic        a_blocked;
		logic        b_open_bus;
		logic        channel_finished;
	} dcas_out_t;

	typedef struct packed {
		logic load;
		logic start;
		logic exec;
	} dcas_cmd_t;

	typedef struct packed {
		logic res_free;
	} dcas_stat_t;

	function automatic logic [1:0] pattern_offset(input logic [2:0] mode,
			input logic [1:0] phase);
		logic [1:0] off;
		case (mode) inside
			3'd1, 3'd5: off = {1'b0, phase[0]};
			3'd3, 3'd7: off = {1'b0, phase[1]};
			3'd4:       off = phase;
			default:    off = 2'd0;
		endcase
		return off;
	endfunction

	function automatic logic addr_blocked(input logic [23:0] a);
		return ((a & BLK_PAGE_MASK) == BLK_PAGE_VAL) ||
			((a & BLK_DMA_MASK) == BLK_DMA_VAL) ||
			((a & BLK_REG_MASK) == BLK_MDMA_VAL) ||
			((a & BLK_REG_MASK) == BLK_HDMA_VAL);
	endfunction

endpackage

FILE: design/dcas_in_if.sv
// Request channel carrying load, start and step items
interface dcas_in_if import dcas_pkg::*; ();
	logic     valid;
	logic     ready;
	dcas_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/dcas_out_if.sv
// Response channel carrying one bus transfer descriptor per step
interface dcas_out_if import dcas_pkg::*; ();
	logic      valid;
	logic      ready;
	dcas_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/dma_channel_address_sequencer.sv
// Load and start items are applied as they are accepted; a step item moves the controller
// to its exec state, where the pick and address update are done and the descriptor is
// registered at the output, so a new item is taken only once the step has executed.
// A step waits in the exec state while the output register is full and not taken.
// Asynchronous active-low reset clears all channel settings, the active mask and
// the output valid.
`include "assert_macros.svh"

module dma_channel_address_sequencer import dcas_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input logic clk,
	input logic arst_n,
	dcas_in_if.sink   req,
	dcas_out_if.source rsp
);

	dcas_cmd_t  cmd;
	dcas_stat_t stat;
	logic       step_xfer;
	logic       rsp_idle;
	logic       idle_clean;

	dcas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.opcode   (req.data.opcode),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dcas_dpath #(
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (req.data),
		.res_ready (rsp.ready),
		.stat      (stat),
		.res       (rsp.data),
		.res_valid (rsp.valid)
	);

	assign step_xfer  = req.valid && req.ready && (req.data.opcode == OP_STEP);
	assign rsp_idle   = rsp.valid && rsp.data.idle;
	assign idle_clean = (rsp.data.a_address == 24'd0) && !rsp.data.channel_finished;

	`AST_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
	`AST_NEXT(a_step_busy, step_xfer, !req.ready, "step transfer not followed by busy")
	`AST_NEXT(a_exec_result, cmd.exec, rsp.valid, "executed step produced no result")
	`AST_SAME(a_idle_zero, rsp_idle, idle_clean, "idle result carries nonzero fields")

endmodule

FILE: design/dcas_ctrl.sv
// Controller state machine: accepts items and sequences the step execution
module dcas_ctrl import dcas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] opcode,
	output logic       in_ready,
	input  dcas_stat_t stat,
	output dcas_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.start = 1'b0;
		cmd.exec  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = accept && (opcode == OP_LOAD);
				cmd.start = accept && (opcode == OP_START);
				if (accept && (opcode == OP_STEP)) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.res_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/dcas_dpath.sv
// Datapath: channel settings, priority pick, address generation, result register
module dcas_dpath import dcas_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dcas_cmd_t  cmd,
	input  dcas_in_t   item,
	input  logic       res_ready,
	output dcas_stat_t stat,
	output dcas_out_t  res,
	output logic       res_valid
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [CHANNELS-1:0] active_q;
	logic [CHANNELS-1:0] dir_q;
	logic [CHANNELS-1:0] fixed_q;
	logic [CHANNELS-1:0] down_q;
	logic [2:0]          pattern_q [CHANNELS];
	logic [7:0]          b_base_q  [CHANNELS];
	logic [7:0]          bank_q    [CHANNELS];
	logic [15:0]         addr_q    [CHANNELS];
	logic [15:0]         count_q   [CHANNELS];
	logic [1:0]          phase_q   [CHANNELS];

	dcas_out_t  res_q, res_d;
	logic       res_valid_q;
	logic       found;
	logic [IDX_W-1:0] pick;
	logic [IDX_W-1:0] widx;
	logic       load_hit;
	logic [23:0] cur_a;
	logic [7:0]  cur_b;
	logic [15:0] next_addr;

	assign widx     = item.channel_sel[IDX_W-1:0];
	assign load_hit = int'(item.channel_sel) < CHANNELS;

	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (active_q[i]) begin
				found = 1'b1;
				pick  = IDX_W'(i);
			end
		end
	end

	assign cur_a = {bank_q[pick], addr_q[pick]};
	assign cur_b = b_base_q[pick] + {6'd0, pattern_offset(pattern_q[pick], phase_q[pick])};

	always_comb begin
		if (fixed_q[pick]) begin
			next_addr = addr_q[pick];
		end else if (down_q[pick]) begin
			next_addr = addr_q[pick] - 16'd1;
		end else begin
			next_addr = addr_q[pick] + 16'd1;
		end
	end

	always_comb begin
		res_d = '0;
		if (!found) begin
			res_d.idle = 1'b1;
		end else begin
			res_d.served_channel   = 3'(pick);
			res_d.a_address        = cur_a;
			res_d.b_register       = cur_b;
			res_d.b_to_a           = dir_q[pick];
			res_d.a_blocked        = addr_blocked(cur_a);
			res_d.b_open_bus       = dir_q[pick] && (cur_b == B_OPEN_REG);
			res_d.channel_finished = (count_q[pick] == 16'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			dir_q    <= '0;
			fixed_q  <= '0;
			down_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pattern_q[i] <= '0;
				b_base_q[i]  <= '0;
				bank_q[i]    <= '0;
				addr_q[i]    <= '0;
				count_q[i]   <= '0;
				phase_q[i]   <= '0;
			end
		end else begin
			if (cmd.load && load_hit) begin
				dir_q[widx]     <= item.b_to_a_dir;
				fixed_q[widx]   <= item.fixed_address;
				down_q[widx]    <= item.step_down;
				pattern_q[widx] <= item.pattern_mode;
				b_base_q[widx]  <= item.b_base;
				bank_q[widx]    <= item.src_bank;
				addr_q[widx]    <= item.src_address;
				count_q[widx]   <= item.byte_count;
			end
			if (cmd.start) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (item.enable_mask[i]) begin
						active_q[i] <= 1'b1;
						phase_q[i]  <= '0;
					end
				end
			end
			if (cmd.exec && found) begin
				addr_q[pick]  <= next_addr;
				count_q[pick] <= count_q[pick] - 16'd1;
				phase_q[pick] <= phase_q[pick] + 2'd1;
				if (count_q[pick] == 16'd1) begin
					active_q[pick] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign stat.res_free = !res_valid_q || res_ready;
	assign res           = res_q;
	assign res_valid     = res_valid_q;

endmodule

FILE: bench/tb_dma_channel_address_sequencer.sv
// Testbench for the DMA channel address sequencer: directed table, random sequences, predictor
module tb_dma_channel_address_sequencer;
	import dcas_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam dcas_out_t IDLE_XFER = '{idle: 1'b1, default: '0};

	typedef struct {
		dcas_in_t  item;
		bit        typed;
		dcas_out_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dcas_in_if  req_if ();
	dcas_out_if rsp_if ();

	dma_channel_address_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	// predicted channel state
	bit         ch_active [8];
	bit         ch_dir [8];
	bit         ch_fixed [8];
	bit         ch_down [8];
	bit  [2:0]  ch_pattern [8];
	bit  [7:0]  ch_base [8];
	bit  [7:0]  ch_bank [8];
	bit  [15:0] ch_addr [8];
	bit  [15:0] ch_left [8];
	bit  [1:0]  ch_phase [8];

	dcas_out_t  pending_xfers [$];
	stim_row_t  stim_rows [$];
	dcas_out_t  want_xf;
	int         errors = 0;
	int         items_sent = 0;
	int         burst_left = 1;
	bit         req_on = 1'b0;
	bit         paused = 1'b0;
	int         rx_cyc = 0;
	int         rx_mode = 0;

	function automatic bit a_is_blocked(input logic [23:0] a);
		if (a[22])
			return 1'b0;
		return a[15:8] == 8'h21 || a[15:7] == 9'h086 ||
			a[15:0] == 16'h420b || a[15:0] == 16'h420c;
	endfunction

	function automatic bit next_transfer(input dcas_in_t it, output dcas_out_t xf);
		int c;
		bit found;
		logic [1:0] off;
		logic [23:0] a;
		logic [7:0] b;
		xf = '0;
		found = 1'b0;
		c = 0;
		case (it.opcode)
			OP_LOAD: begin
				ch_dir[it.channel_sel]     = it.b_to_a_dir;
				ch_fixed[it.channel_sel]   = it.fixed_address;
				ch_down[it.channel_sel]    = it.step_down;
				ch_pattern[it.channel_sel] = it.pattern_mode;
				ch_base[it.channel_sel]    = it.b_base;
				ch_bank[it.channel_sel]    = it.src_bank;
				ch_addr[it.channel_sel]    = it.src_address;
				ch_left[it.channel_sel]    = it.byte_count;
				return 1'b0;
			end
			OP_START: begin
				for (int i = 0; i < 8; i++) begin
					if (it.enable_mask[i]) begin
						ch_active[i] = 1'b1;
						ch_phase[i] = 2'd0;
					end
				end
				return 1'b0;
			end
			OP_STEP: begin
				for (int i = 0; i < 8; i++) begin
					if (ch_active[i] && !found) begin
						found = 1'b1;
						c = i;
					end
				end
				if (!found) begin
					xf.idle = 1'b1;
					return 1'b1;
				end
				case (ch_pattern[c]) inside
					3'd1, 3'd5: off = {1'b0, ch_phase[c][0]};
					3'd3, 3'd7: off = {1'b0, ch_phase[c][1]};
					3'd4:       off = ch_phase[c];
					default:    off = 2'd0;
				endcase
				a = {ch_bank[c], ch_addr[c]};
				b = ch_base[c] + 8'(off);
				if (!ch_fixed[c])
					ch_addr[c] = ch_down[c] ? ch_addr[c] - 16'd1 : ch_addr[c] + 16'd1;
				ch_left[c] = ch_left[c] - 16'd1;
				ch_phase[c] = ch_phase[c] + 2'd1;
				if (ch_left[c] == 16'd0)
					ch_active[c] = 1'b0;
				xf.served_channel   = 3'(c);
				xf.a_address        = a;
				xf.b_register       = b;
				xf.b_to_a           = ch_dir[c];
				xf.a_blocked        = a_is_blocked(a);
				xf.b_open_bus       = ch_dir[c] && b == B_OPEN_REG;
				xf.channel_finished = !ch_active[c];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic dcas_in_t mk_other(input logic [1:0] op);
		logic [95:0] raw;
		dcas_in_t it;
		raw = {$urandom, $urandom, $urandom};
		it = raw[$bits(dcas_in_t)-1:0];
		it.opcode = op;
		return it;
	endfunction

	function automatic dcas_in_t mk_start(input logic [7:0] mask);
		dcas_in_t it;
		it = mk_other(OP_START);
		it.enable_mask = mask;
		return it;
	endfunction

	function automatic dcas_in_t mk_load(input logic [2:0] ch, input logic dir, fx, dn,
			input logic [2:0] pat, input logic [7:0] base, bank,
			input logic [15:0] addr, cnt);
		dcas_in_t it;
		it = mk_other(OP_LOAD);
		it.channel_sel   = ch;
		it.b_to_a_dir    = dir;
		it.fixed_address = fx;
		it.step_down     = dn;
		it.pattern_mode  = pat;
		it.b_base        = base;
		it.src_bank      = bank;
		it.src_address   = addr;
		it.byte_count    = cnt;
		return it;
	endfunction

	function automatic dcas_out_t mk_xfer(input logic [2:0] ch, input logic [23:0] a,
			input logic [7:0] b, input logic dir, blk, opn, fin);
		dcas_out_t xf;
		xf = '0;
		xf.served_channel   = ch;
		xf.a_address        = a;
		xf.b_register       = b;
		xf.b_to_a           = dir;
		xf.a_blocked        = blk;
		xf.b_open_bus       = opn;
		xf.channel_finished = fin;
		return xf;
	endfunction

	function automatic dcas_in_t rand_load(input logic [2:0] ch);
		logic [7:0] base, bank;
		logic [15:0] addr, cnt;
		base = ($urandom_range(0, 3) == 0) ? 8'h80 - 8'($urandom_range(0, 3)) : 8'($urandom);
		bank = 8'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				bank[6] = 1'b0;
				addr = {8'h21, 8'($urandom)};
			end
			1: addr = 16'h4300 + 16'($urandom_range(0, 255));
			2: addr = 16'h420a + 16'($urandom_range(0, 3));
			3: addr = 16'($urandom_range(0, 2));
			4: addr = 16'hffff - 16'($urandom_range(0, 2));
			default: addr = 16'($urandom);
		endcase
		case ($urandom_range(0, 19))
			0: cnt = 16'h0000;
			1: cnt = 16'($urandom);
			default: cnt = 16'($urandom_range(1, 8));
		endcase
		return mk_load(ch, 1'($urandom), $urandom_range(0, 3) == 0, 1'($urandom),
			3'($urandom), base, bank, addr, cnt);
	endfunction

	task automatic add_row(input dcas_in_t it, input bit typed = 1'b0,
			input dcas_out_t want = '0);
		stim_row_t r;
		r.item = it;
		r.typed = typed;
		r.want = want;
		stim_rows.push_back(r);
	endtask

	task automatic send(input dcas_in_t it, input bit typed = 1'b0,
			input dcas_out_t want = '0);
		dcas_out_t xf;
		int gap;
		req_if.data <= it;
		if (!req_on) begin
			req_if.valid <= 1'b1;
			req_on = 1'b1;
		end
		do @(posedge clk); while (req_if.ready !== 1'b1);
		if (next_transfer(it, xf))
			pending_xfers.push_back(typed ? want : xf);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				req_on = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		if (req_on) begin
			req_if.valid <= 1'b0;
			req_on = 1'b0;
		end
		do @(posedge clk); while (pending_xfers.size() != 0);
	endtask

	task automatic run_sequence();
		int n, ch, steps;
		logic [7:0] mask;
		dcas_in_t it;
		n = $urandom_range(1, 3);
		mask = '0;
		steps = 0;
		repeat (n) begin
			ch = $urandom_range(0, 7);
			it = rand_load(3'(ch));
			send(it);
			mask[ch] = 1'b1;
			steps += (it.byte_count == 16'd0 || it.byte_count > 16'd12) ? 12 : it.byte_count;
		end
		if ($urandom_range(0, 4) == 0)
			mask |= 8'($urandom);
		send(mk_start(mask));
		steps += $urandom_range(0, 2);
		repeat (steps) begin
			if ($urandom_range(0, 9) == 0)
				send(rand_load(3'($urandom)));
			send(mk_other(OP_STEP));
		end
	endtask

	task automatic check_fld(input string name, input int unsigned exp, act);
		if (exp != act) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_xfers.size() == 0) begin
				$error("transfer with none expected: %p", rsp_if.data);
				errors++;
			end else begin
				want_xf = pending_xfers.pop_front();
				check_fld("idle", want_xf.idle, rsp_if.data.idle);
				check_fld("served_channel", want_xf.served_channel,
					rsp_if.data.served_channel);
				check_fld("a_address", want_xf.a_address, rsp_if.data.a_address);
				check_fld("b_register", want_xf.b_register, rsp_if.data.b_register);
				check_fld("b_to_a", want_xf.b_to_a, rsp_if.data.b_to_a);
				check_fld("a_blocked", want_xf.a_blocked, rsp_if.data.a_blocked);
				check_fld("b_open_bus", want_xf.b_open_bus, rsp_if.data.b_open_bus);
				check_fld("channel_finished", want_xf.channel_finished,
					rsp_if.data.channel_finished);
			end
		end
	end

	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_cyc % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= $urandom_range(0, 3) != 0;
				2: rsp_if.ready <= rx_cyc[0];
				default: rsp_if.ready <= rx_cyc[2:0] == 3'd0;
			endcase
			rx_cyc++;
		end
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		add_row(mk_other(OP_STEP), 1'b1, IDLE_XFER);
		add_row(mk_start(8'h00));
		add_row(mk_other(OP_STEP), 1'b1, IDLE_XFER);
		add_row(mk_load(3'd7, 1'b1, 1'b0, 1'b0, 3'd4, 8'hff, 8'hff, 16'hffff, 16'd1));
		add_row(mk_start(8'h80));
		add_row(mk_other(OP_STEP), 1'b1,
			mk_xfer(3'd7, 24'hffffff, 8'hff, 1'b1, 1'b0, 1'b0, 1'b1));
		add_row(mk_load(3'd1, 1'b1, 1'b1, 1'b0, 3'd0, 8'h80, 8'h00, 16'h2100, 16'd2));
		add_row(mk_start(8'h02));
		add_row(mk_other(OP_STEP), 1'b1,
			mk_xfer(3'd1, 24'h002100, 8'h80, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(mk_other(OP_STEP), 1'b1,
			mk_xfer(3'd1, 24'h002100, 8'h80, 1'b1, 1'b1, 1'b1, 1'b1));
		add_row(mk_other(OP_UNUSED));
		add_row(mk_other(OP_STEP), 1'b1, IDLE_XFER);
		add_row(mk_load(3'd0, 1'b0, 1'b0, 1'b1, 3'd4, 8'hfe, 8'h3f, 16'h0000, 16'h0000));
		add_row(mk_load(3'd3, 1'b0, 1'b0, 1'b0, 3'd1, 8'h7f, 8'h00, 16'h437f, 16'd3));
		add_row(mk_start(8'h09));
		repeat (3) add_row(mk_other(OP_STEP));
		add_row(mk_load(3'd0, 1'b1, 1'b0, 1'b0, 3'd3, 8'h7f, 8'h40, 16'h420b, 16'd1));
		repeat (4) add_row(mk_other(OP_STEP));
		add_row(mk_load(3'd5, 1'b0, 1'b0, 1'b0, 3'd5, 8'h00, 8'h00, 16'h420c, 16'd1));
		add_row(mk_start(8'h20));
		add_row(mk_other(OP_STEP));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 24);

		foreach (stim_rows[i])
			send(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
		drain();

		while (items_sent < 1700) begin
			if (!paused && items_sent >= 900) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 8)
				run_sequence();
			else
				repeat ($urandom_range(1, 4)) send(mk_other(2'($urandom)));
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
